// ===== hdl/hvtd_pkg.sv =====
// Package for the haversine track odometer.
// Holds the datapath op codes, the sequencer program, status type and fixed-point constants.
// No dependencies.
package hvtd_pkg;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int RAD_W  = 24;
    localparam int STEP_W = 32;
    localparam int TOT_W  = 48;
    localparam int CW     = 36;   // CORDIC x and y
    localparam int ZW     = 34;   // CORDIC angle
    localparam int QW     = 33;   // Q30 operands and multiplier inputs
    localparam int PW     = 66;   // multiplier product
    localparam int SQ_IN_W   = 62;
    localparam int SQ_ROOT_W = 31;
    localparam int SQ_STEPS  = 31;
    localparam int PC_W   = 6;
    localparam int ACC_W  = 40;   // step distance before output saturation

    localparam logic [31:0] DEG_MUL     = 32'd4024455254;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] GAIN_Q30    = 32'd652032874;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;
    localparam logic signed [34:0] HALF_TURN = 35'sd1800000000;
    localparam logic signed [34:0] FULL_TURN = 35'sd3600000000;
    localparam logic [9:0] MM_PER_M = 10'd1000;

    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_OUTPUT,
        OP_DIFF_LAT, OP_DIFF_LON, OP_MUL_HALF, OP_ROT_HALF, OP_SAVE_SL, OP_SAVE_SG,
        OP_MUL_LAT1, OP_MUL_LAT2, OP_ROT_COS, OP_SAVE_C1, OP_SAVE_C2,
        OP_MUL_CC, OP_SAVE_CC, OP_MUL_SL2, OP_SAVE_A, OP_MUL_SG2, OP_SAVE_HS,
        OP_MUL_CCH, OP_ADD_A, OP_SQRT_X, OP_SAVE_SQX, OP_SQRT_Y, OP_SAVE_SQY,
        OP_VEC, OP_SAVE_ANG, OP_MUL_R, OP_SAVE_TT, OP_MUL_HI, OP_SAVE_HI,
        OP_MUL_LO, OP_ADD_LO, OP_ACCUM
    } t_op;

    typedef struct packed {
        logic have_pos;
        logic busy;
    } t_status;

    localparam logic [PC_W-1:0] PC_LAST = 6'd34;

    function automatic t_op prog_op(input logic [PC_W-1:0] pc);
        t_op op;
        case (pc)
            6'd0:  op = OP_DIFF_LAT;
            6'd1:  op = OP_MUL_HALF;
            6'd2:  op = OP_ROT_HALF;
            6'd3:  op = OP_SAVE_SL;
            6'd4:  op = OP_DIFF_LON;
            6'd5:  op = OP_MUL_HALF;
            6'd6:  op = OP_ROT_HALF;
            6'd7:  op = OP_SAVE_SG;
            6'd8:  op = OP_MUL_LAT1;
            6'd9:  op = OP_ROT_COS;
            6'd10: op = OP_SAVE_C1;
            6'd11: op = OP_MUL_LAT2;
            6'd12: op = OP_ROT_COS;
            6'd13: op = OP_SAVE_C2;
            6'd14: op = OP_MUL_CC;
            6'd15: op = OP_SAVE_CC;
            6'd16: op = OP_MUL_SL2;
            6'd17: op = OP_SAVE_A;
            6'd18: op = OP_MUL_SG2;
            6'd19: op = OP_SAVE_HS;
            6'd20: op = OP_MUL_CCH;
            6'd21: op = OP_ADD_A;
            6'd22: op = OP_SQRT_X;
            6'd23: op = OP_SAVE_SQX;
            6'd24: op = OP_SQRT_Y;
            6'd25: op = OP_SAVE_SQY;
            6'd26: op = OP_VEC;
            6'd27: op = OP_SAVE_ANG;
            6'd28: op = OP_MUL_R;
            6'd29: op = OP_SAVE_TT;
            6'd30: op = OP_MUL_HI;
            6'd31: op = OP_SAVE_HI;
            6'd32: op = OP_MUL_LO;
            6'd33: op = OP_ADD_LO;
            6'd34: op = OP_ACCUM;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    // ops that launch a multi-cycle unit
    function automatic logic is_start(input t_op op);
        return (op == OP_ROT_HALF) || (op == OP_ROT_COS) || (op == OP_SQRT_X) ||
               (op == OP_SQRT_Y) || (op == OP_VEC);
    endfunction

    function automatic logic [29:0] atan_q30(input int unsigned i);
        logic [29:0] a;
        case (i)
            0:  a = 30'd843314856;
            1:  a = 30'd497837829;
            2:  a = 30'd263043836;
            3:  a = 30'd133525158;
            4:  a = 30'd67021686;
            5:  a = 30'd33543515;
            6:  a = 30'd16775850;
            7:  a = 30'd8388437;
            8:  a = 30'd4194282;
            9:  a = 30'd2097149;
            10: a = 30'd1048575;
            11: a = 30'd524287;
            12: a = 30'd262143;
            13: a = 30'd131071;
            14: a = 30'd65535;
            15: a = 30'd32767;
            16: a = 30'd16383;
            17: a = 30'd8191;
            18: a = 30'd4095;
            19: a = 30'd2047;
            20: a = 30'd1023;
            21: a = 30'd511;
            22: a = 30'd255;
            23: a = 30'd127;
            24: a = 30'd63;
            25: a = 30'd31;
            26: a = 30'd15;
            27: a = 30'd8;
            28: a = 30'd4;
            29: a = 30'd2;
            30: a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/haversine_track_distance.sv =====
// From input beat to result beat: a first fix goes straight to output; later fixes run five
// CORDIC runs of CORDIC_ITERATIONS micro-rotations each, two 31-step square roots and the
// sequencer steps between them.
// The block takes no new fix while one is in work; the next fix is taken while a result waits for its beat.
// Reset (synchronous, active low): no stored position, total zero, radius 6371000 m.
// Top level of the track odometer. Depends on hvtd_pkg, hvtd_ctrl and hvtd_dp.
module haversine_track_distance #(
    parameter int CORDIC_ITERATIONS = 32,
    parameter int DISTANCE_WIDTH    = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // fix input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [30:0] latitude, [62:31] longitude, [63] zero
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] step_distance_mm, [79:32] total_distance_mm
    output logic        m_tuser,   // [0] first_fix
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic REG_RADIUS = 1'b0;

    logic [hvtd_pkg::RAD_W-1:0]  r_radius;
    hvtd_pkg::t_op               op;
    hvtd_pkg::t_status           status;
    logic [hvtd_pkg::STEP_W-1:0] step;
    logic [hvtd_pkg::TOT_W-1:0]  total;
    logic                        first;

    // radius register, also at addresses 1 to 3 (paddr[2] low); writes with paddr[2] high are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 24'd6371000;
        end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
            r_radius <= pwdata[hvtd_pkg::RAD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_RADIUS) ? 32'(r_radius) : 32'd0;
    assign pready = 1'b1;

    hvtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_status   (status),
        .o_op       (op)
    );

    hvtd_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .DISTANCE_WIDTH    (DISTANCE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_radius (r_radius),
        .i_lat    (signed'(s_tdata[30:0])),
        .i_lon    (signed'(s_tdata[62:31])),
        .o_status (status),
        .o_step   (step),
        .o_total  (total),
        .o_first  (first)
    );

    assign m_tdata = {total, step};
    assign m_tuser = first;
endmodule

// ===== hdl/hvtd_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on hvtd_pkg (widths, arctangent table).
module hvtd_cordic #(
    parameter int ITER = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_vec,
    input  logic signed [hvtd_pkg::CW-1:0] i_x0,
    input  logic signed [hvtd_pkg::CW-1:0] i_y0,
    input  logic signed [hvtd_pkg::ZW-1:0] i_z0,
    output logic signed [hvtd_pkg::CW-1:0] o_x,
    output logic signed [hvtd_pkg::CW-1:0] o_y,
    output logic signed [hvtd_pkg::ZW-1:0] o_z,
    output logic                          o_busy
);
    localparam int IW = $clog2(ITER);

    logic                          r_busy;
    logic                          r_vec;
    logic [IW-1:0]                 r_i;
    logic signed [hvtd_pkg::CW-1:0] r_x, r_y;
    logic signed [hvtd_pkg::ZW-1:0] r_z;
    logic signed [hvtd_pkg::CW-1:0] dx, dy;
    logic signed [hvtd_pkg::ZW-1:0] da;
    logic                          up;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign da = signed'({4'b0000, hvtd_pkg::atan_q30(int'(r_i))});
    // rotate toward zero angle, or toward zero y
    assign up = r_vec ? !(r_y > 0) : !r_z[hvtd_pkg::ZW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == IW'(ITER - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x0;
            r_y   <= i_y0;
            r_z   <= i_z0;
            r_vec <= i_vec;
        end else if (r_busy) begin
            if (up) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_busy = r_busy;
endmodule

// ===== hdl/hvtd_sqrt.sv =====
// Bit-serial integer square root, one root bit per cycle, floor result.
// Depends on hvtd_pkg (widths).
module hvtd_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [hvtd_pkg::SQ_IN_W-1:0]      i_value,
    output logic [hvtd_pkg::SQ_ROOT_W-1:0]    o_root,
    output logic                              o_busy
);
    logic                             r_busy;
    logic [4:0]                       r_cnt;
    logic [hvtd_pkg::SQ_IN_W-1:0]     r_v;
    logic [32:0]                      r_rem;
    logic [hvtd_pkg::SQ_ROOT_W-1:0]   r_root;
    logic [34:0]                      rem_sh;
    logic [34:0]                      trial;
    logic                             fit;

    assign rem_sh = {r_rem, r_v[hvtd_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 5'(hvtd_pkg::SQ_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v <= {r_v[hvtd_pkg::SQ_IN_W-3:0], 2'b00};
            if (fit) begin
                r_rem  <= 33'(rem_sh - trial);
                r_root <= {r_root[hvtd_pkg::SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[32:0];
                r_root <= {r_root[hvtd_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_busy = r_busy;
endmodule

// ===== hdl/hvtd_dp.sv =====
// Datapath: fix registers, shared multiplier, CORDIC and square-root units, odometer total.
// Depends on hvtd_pkg, hvtd_cordic and hvtd_sqrt.
module hvtd_dp #(
    parameter int CORDIC_ITERATIONS = 32,
    parameter int DISTANCE_WIDTH    = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hvtd_pkg::t_op                      i_op,
    input  logic [hvtd_pkg::RAD_W-1:0]         i_radius,
    input  logic signed [hvtd_pkg::LAT_W-1:0]  i_lat,
    input  logic signed [hvtd_pkg::LON_W-1:0]  i_lon,
    output hvtd_pkg::t_status                  o_status,
    output logic [hvtd_pkg::STEP_W-1:0]        o_step,
    output logic [hvtd_pkg::TOT_W-1:0]         o_total,
    output logic                               o_first
);
    localparam int DW = DISTANCE_WIDTH;
    localparam int SW = ((DW > hvtd_pkg::ACC_W) ? DW : hvtd_pkg::ACC_W) + 1;
    localparam int CW = hvtd_pkg::CW;
    localparam int ZW = hvtd_pkg::ZW;
    localparam int QW = hvtd_pkg::QW;
    localparam int PW = hvtd_pkg::PW;

    logic signed [hvtd_pkg::LAT_W-1:0] r_lat1, r_lat2;
    logic signed [hvtd_pkg::LON_W-1:0] r_lon1, r_lon2;
    logic                  r_have_pos, r_first, r_cneg;
    logic signed [31:0]    r_d;
    logic signed [PW-1:0]  r_prod;
    logic signed [QW-1:0]  r_sl, r_sg, r_c1, r_c2, r_cc, r_hs;
    logic signed [34:0]    r_a;
    logic [hvtd_pkg::SQ_ROOT_W-1:0] r_sqx, r_sqy;
    logic [31:0]           r_ang;
    logic [55:0]           r_tt;
    logic [hvtd_pkg::ACC_W-1:0] r_step;
    logic [DW-1:0]         r_total;
    logic [hvtd_pkg::STEP_W-1:0] r_out_step;
    logic [hvtd_pkg::TOT_W-1:0]  r_out_total;
    logic                  r_out_first;

    logic signed [QW-1:0]  mul_a, mul_b;
    logic signed [34:0]    diff;
    logic signed [34:0]    red;
    logic [31:0]           mag_d, mag_lat;
    logic [63:0]           half_sum, cos_sum;
    logic [31:0]           h, u;
    logic signed [PW-1:0]  rnd_full;
    logic signed [QW-1:0]  rnd;
    logic signed [34:0]    a_sum;
    logic [30:0]           a_clamp;
    logic [39:0]           lo_sum;
    logic [SW-1:0]         tot_sum;
    logic [63:0]           tot64;

    logic                  c_start, c_vec, c_busy;
    logic signed [CW-1:0]  c_x0, c_y0, c_x, c_y;
    logic signed [ZW-1:0]  c_z0, c_z;
    logic                  s_start, s_busy;
    logic [hvtd_pkg::SQ_IN_W-1:0]   s_val;
    logic [hvtd_pkg::SQ_ROOT_W-1:0] s_root;

    // latitude or longitude difference folded into half a turn either way
    always_comb begin
        if (i_op == hvtd_pkg::OP_DIFF_LAT) begin
            diff = 35'(r_lat2) - 35'(r_lat1);
        end else begin
            diff = 35'(r_lon2) - 35'(r_lon1);
        end
        if (diff >= hvtd_pkg::HALF_TURN) begin
            red = diff - hvtd_pkg::FULL_TURN;
        end else if (diff < -hvtd_pkg::HALF_TURN) begin
            red = diff + hvtd_pkg::FULL_TURN;
        end else begin
            red = diff;
        end
    end

    assign mag_d    = r_d[31] ? 32'(-r_d) : 32'(r_d);
    assign mag_lat  = (i_op == hvtd_pkg::OP_MUL_LAT1)
                      ? (r_lat1[30] ? 32'(-33'(r_lat1)) : 32'(r_lat1))
                      : (r_lat2[30] ? 32'(-33'(r_lat2)) : 32'(r_lat2));
    assign half_sum = r_prod[63:0] + 64'h8000_0000;
    assign cos_sum  = r_prod[63:0] + 64'h4000_0000;
    assign h        = half_sum[63:32];
    assign u        = cos_sum[62:31];
    assign rnd_full = (r_prod + PW'(64'sd536870912)) >>> 30;
    assign rnd      = rnd_full[QW-1:0];
    assign a_sum    = r_a + 35'(rnd);
    assign a_clamp  = a_sum[34] ? 31'd0
                    : (a_sum > 35'(hvtd_pkg::ONE_Q30)) ? 31'(hvtd_pkg::ONE_Q30) : a_sum[30:0];
    assign lo_sum   = r_prod[39:0] + 40'h2000_0000;
    assign tot_sum  = SW'(r_total) + SW'(r_step);
    assign tot64    = 64'(r_total);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            hvtd_pkg::OP_MUL_HALF: begin
                mul_a = signed'({1'b0, mag_d});
                mul_b = signed'({1'b0, hvtd_pkg::DEG_MUL});
            end
            hvtd_pkg::OP_MUL_LAT1, hvtd_pkg::OP_MUL_LAT2: begin
                mul_a = signed'({1'b0, mag_lat});
                mul_b = signed'({1'b0, hvtd_pkg::DEG_MUL});
            end
            hvtd_pkg::OP_MUL_CC: begin
                mul_a = r_c1;
                mul_b = r_c2;
            end
            hvtd_pkg::OP_MUL_SL2: begin
                mul_a = r_sl;
                mul_b = r_sl;
            end
            hvtd_pkg::OP_MUL_SG2: begin
                mul_a = r_sg;
                mul_b = r_sg;
            end
            hvtd_pkg::OP_MUL_CCH: begin
                mul_a = r_cc;
                mul_b = r_hs;
            end
            hvtd_pkg::OP_MUL_R: begin
                mul_a = signed'({9'd0, i_radius});
                mul_b = signed'({1'b0, r_ang});
            end
            hvtd_pkg::OP_MUL_HI: begin
                mul_a = signed'({7'd0, r_tt[55:30]});
                mul_b = signed'({23'd0, hvtd_pkg::MM_PER_M});
            end
            hvtd_pkg::OP_MUL_LO: begin
                mul_a = signed'({3'd0, r_tt[29:0]});
                mul_b = signed'({23'd0, hvtd_pkg::MM_PER_M});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // unit launch
    always_comb begin
        c_start = 1'b0;
        c_vec   = 1'b0;
        c_x0    = CW'(signed'({1'b0, hvtd_pkg::GAIN_Q30}));
        c_y0    = '0;
        c_z0    = '0;
        s_start = 1'b0;
        s_val   = {1'b0, 31'(32'(hvtd_pkg::ONE_Q30) - 32'(r_a[30:0])), 30'd0};
        case (i_op)
            hvtd_pkg::OP_ROT_HALF: begin
                c_start = 1'b1;
                c_z0    = r_d[31] ? -ZW'(h) : ZW'(h);
            end
            hvtd_pkg::OP_ROT_COS: begin
                c_start = 1'b1;
                c_z0    = (u > hvtd_pkg::HALF_PI_Q30) ? ZW'(hvtd_pkg::PI_Q30) - ZW'(u) : ZW'(u);
            end
            hvtd_pkg::OP_VEC: begin
                c_start = 1'b1;
                c_vec   = 1'b1;
                c_x0    = CW'(r_sqx);
                c_y0    = CW'(r_sqy);
            end
            hvtd_pkg::OP_SQRT_X: begin
                s_start = 1'b1;
            end
            hvtd_pkg::OP_SQRT_Y: begin
                s_start = 1'b1;
                s_val   = {1'b0, r_a[30:0], 30'd0};
            end
            default: begin
                c_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_pos <= 1'b0;
            r_total    <= '0;
            r_lat1     <= '0;
            r_lon1     <= '0;
        end else begin
            case (i_op)
                hvtd_pkg::OP_LOAD: begin
                    r_lat2  <= i_lat;
                    r_lon2  <= i_lon;
                    r_first <= !r_have_pos;
                end
                hvtd_pkg::OP_DIFF_LAT, hvtd_pkg::OP_DIFF_LON: r_d <= 32'(red);
                hvtd_pkg::OP_ROT_HALF: r_cneg <= 1'b0;
                hvtd_pkg::OP_ROT_COS:  r_cneg <= u > hvtd_pkg::HALF_PI_Q30;
                hvtd_pkg::OP_SAVE_SL:  r_sl <= QW'(c_y);
                hvtd_pkg::OP_SAVE_SG:  r_sg <= QW'(c_y);
                hvtd_pkg::OP_SAVE_C1:  r_c1 <= r_cneg ? -QW'(c_x) : QW'(c_x);
                hvtd_pkg::OP_SAVE_C2:  r_c2 <= r_cneg ? -QW'(c_x) : QW'(c_x);
                hvtd_pkg::OP_SAVE_CC:  r_cc <= rnd;
                hvtd_pkg::OP_SAVE_A:   r_a  <= 35'(rnd);
                hvtd_pkg::OP_SAVE_HS:  r_hs <= rnd;
                hvtd_pkg::OP_ADD_A:    r_a  <= 35'(a_clamp);
                hvtd_pkg::OP_SAVE_SQX: r_sqx <= s_root;
                hvtd_pkg::OP_SAVE_SQY: r_sqy <= s_root;
                hvtd_pkg::OP_SAVE_ANG: begin
                    if (c_z[ZW-1]) begin
                        r_ang <= '0;
                    end else if (c_z > ZW'(hvtd_pkg::HALF_PI_Q30)) begin
                        r_ang <= {hvtd_pkg::HALF_PI_Q30[30:0], 1'b0};
                    end else begin
                        r_ang <= {c_z[30:0], 1'b0};
                    end
                end
                hvtd_pkg::OP_SAVE_TT: r_tt   <= r_prod[55:0];
                hvtd_pkg::OP_SAVE_HI: r_step <= r_prod[39:0];
                hvtd_pkg::OP_ADD_LO:  r_step <= r_step + 40'(lo_sum[39:30]);
                hvtd_pkg::OP_ACCUM: begin
                    // saturate the running total
                    if (tot_sum > SW'({DW{1'b1}})) begin
                        r_total <= '1;
                    end else begin
                        r_total <= tot_sum[DW-1:0];
                    end
                end
                hvtd_pkg::OP_OUTPUT: begin
                    if (r_first) begin
                        r_out_step <= '0;
                    end else if (r_step > 40'(32'hFFFF_FFFF)) begin
                        r_out_step <= '1;
                    end else begin
                        r_out_step <= r_step[31:0];
                    end
                    r_out_total <= tot64[hvtd_pkg::TOT_W-1:0];
                    r_out_first <= r_first;
                    r_lat1      <= r_lat2;
                    r_lon1      <= r_lon2;
                    r_have_pos  <= 1'b1;
                end
                default: begin
                    r_have_pos <= r_have_pos;
                end
            endcase
        end
    end

    hvtd_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_vec   (c_vec),
        .i_x0    (c_x0),
        .i_y0    (c_y0),
        .i_z0    (c_z0),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z),
        .o_busy  (c_busy)
    );

    hvtd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_value (s_val),
        .o_root  (s_root),
        .o_busy  (s_busy)
    );

    assign o_status.have_pos = r_have_pos;
    assign o_status.busy     = c_busy | s_busy;
    assign o_step            = r_out_step;
    assign o_total           = r_out_total;
    assign o_first           = r_out_first;
endmodule

// ===== hdl/hvtd_ctrl.sv =====
// Controller: accepts fixes, steps the datapath program, waits on units, hands off results.
// Depends on hvtd_pkg.
module hvtd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  hvtd_pkg::t_status i_status,
    output hvtd_pkg::t_op     o_op
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [hvtd_pkg::PC_W-1:0]   r_pc, n_pc;
    logic                        r_out_valid, n_out_valid;
    hvtd_pkg::t_op               op;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && !i_m_tready;
        op          = hvtd_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    op      = hvtd_pkg::OP_LOAD;
                    n_pc    = '0;
                    n_state = i_status.have_pos ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                op = hvtd_pkg::prog_op(r_pc);
                if (hvtd_pkg::is_start(op)) begin
                    n_state = S_WAIT;
                end else if (r_pc == hvtd_pkg::PC_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            S_WAIT: begin
                if (!i_status.busy) begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_RUN;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    op          = hvtd_pkg::OP_OUTPUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_op       = op;

`ifndef NO_ASSERTIONS
    a_wait_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> hvtd_pkg::is_start(hvtd_pkg::prog_op(r_pc)))
        else $error("waiting on a step that launches no unit");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second fix taken while one is in work");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == hvtd_pkg::OP_OUTPUT) |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before it was taken");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= hvtd_pkg::PC_LAST)
        else $error("program counter past last step");
`endif
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for haversine_track_distance: stream fixes in, check results out.
// Predicts step and total distance with a fixed-point haversine model. Depends on the DUT only.
`timescale 1ns / 100ps

module tb;

    localparam int  RESET_CYCLES = 12;
    localparam int  DRAIN_CYCLES = 400;     // outlasts the work on one fix at 32 CORDIC iterations
    localparam int  CYCLE_LIMIT  = 4000000;
    localparam int  CORDIC_STEPS = 32;
    localparam int  RANDOM_PER_PHASE = 222;
    localparam logic [2:0] ADDR_RADIUS = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    localparam longint unsigned PI62     = 64'hC90FDAA22168C234;
    localparam longint          PI30     = longint'((PI62 + 64'h80000000) >> 32);
    localparam longint          HALFPI30 = PI30 / 2;
    localparam longint unsigned DEGM     = (PI62 + 64'd1800000000) / 64'd3600000000;
    localparam longint          GAIN30   = 652032874;
    localparam longint          ONE30    = longint'(1) << 30;
    localparam longint          TURN     = 64'sd3600000000;
    localparam longint          HTURN    = 64'sd1800000000;
    localparam longint unsigned TOT_MAX  = (64'd1 << 48) - 1;

    typedef struct packed {
        logic [31:0] step_mm;
        logic [47:0] total_mm;
        logic        first;
    } t_track_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [30:0] latitude, [62:31] longitude, [63] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // [31:0] step_distance_mm, [79:32] total_distance_mm
    logic        m_tuser;   // [0] first_fix
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    haversine_track_distance dut (.*);

    // clock: 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    logic [63:0]   fix_queue[$];
    t_track_result result_queue[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            hold_at = -1;
    int            hold_cnt = 0;

    // odometer state mirrored by the predictor
    longint unsigned radius_m;
    longint          last_lat;
    longint          last_lon;
    bit              have_fix;
    longint unsigned odo_total;

    longint atan_tab [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2, 1, 0
    };

    function automatic longint qmul(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint wrap_turn(longint d);
        longint r;
        r = (d + HTURN) % TURN;
        if (r < 0) r += TURN;
        return r - HTURN;
    endfunction

    function automatic longint to_half_rad(longint d);
        longint unsigned m;
        longint h;
        m = (d < 0) ? -d : d;
        h = longint'((m * DEGM + 64'h80000000) >> 32);
        return (d < 0) ? -h : h;
    endfunction

    function automatic void cordic_rotate(input longint ang, output longint c,
                                          output longint s);
        longint x, y, z, dx, dy;
        x = GAIN30;
        y = 0;
        z = ang;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint sin_of(longint ang);
        longint c, s;
        cordic_rotate(ang, c, s);
        return s;
    endfunction

    // beyond a quarter turn the cosine is folded and negated
    function automatic longint cos_of_lat(longint lat);
        longint unsigned m;
        longint u, c, s;
        m = (lat < 0) ? -lat : lat;
        u = longint'((m * DEGM + 64'h40000000) >> 31);
        if (u > HALFPI30) begin
            cordic_rotate(PI30 - u, c, s);
            return -c;
        end
        cordic_rotate(u, c, s);
        return c;
    endfunction

    function automatic longint cordic_atan2(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > HALFPI30) z = HALFPI30;
        return z;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint unsigned leg_mm(longint lat1, longint lon1,
                                               longint lat2, longint lon2);
        longint sl, sg, cc, a, ang;
        longint unsigned t;
        sl = sin_of(to_half_rad(wrap_turn(lat2 - lat1)));
        sg = sin_of(to_half_rad(wrap_turn(lon2 - lon1)));
        cc = qmul(cos_of_lat(lat1), cos_of_lat(lat2));
        a  = qmul(sl, sl) + qmul(cc, qmul(sg, sg));
        if (a < 0) a = 0;
        if (a > ONE30) a = ONE30;
        ang = 2 * cordic_atan2(int_sqrt(longint'(ONE30 - a) << 30), int_sqrt(a << 30));
        t = radius_m * longint'(ang);
        return (t >> 30) * 1000 + (((t & 64'h3FFFFFFF) * 1000 + 64'h20000000) >> 30);
    endfunction

    // advance the odometer by one fix and return what the block should report
    function automatic t_track_result odometer_update(logic [63:0] beat);
        t_track_result r;
        longint lat, lon;
        longint unsigned step;
        lat = longint'($signed(beat[30:0]));
        lon = longint'($signed(beat[62:31]));
        step = 0;
        r.first = 1'b0;
        if (have_fix) begin
            step = leg_mm(last_lat, last_lon, lat, lon);
            if (step > TOT_MAX - odo_total) odo_total = TOT_MAX;
            else odo_total += step;
        end else begin
            have_fix = 1'b1;
            r.first = 1'b1;
        end
        last_lat = lat;
        last_lon = lon;
        r.step_mm  = (step > 64'hFFFFFFFF) ? 32'hFFFFFFFF : step[31:0];
        r.total_mm = odo_total[47:0];
        return r;
    endfunction

    // driver: present the next fix once the current beat is taken
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                result_queue.push_back(odometer_update(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (fix_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= fix_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: drive backpressure and check each result beat in order
    always @(posedge i_clk) begin
        t_track_result exp_r, got_r;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_r = '{m_tdata[31:0], m_tdata[79:32], m_tuser};
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %h", $time, got_r);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_queue.pop_front();
                    if (exp_r !== got_r) begin
                        $display("%0t: mismatch step expected %0d actual %0d", $time,
                                 exp_r.step_mm, got_r.step_mm);
                        $display("%0t:   total expected %0d actual %0d, first expected %0b actual %0b",
                                 $time, exp_r.total_mm, got_r.total_mm, exp_r.first, got_r.first);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // long hold-off: block fills and stalls the fix input
            if (cycle_count == hold_at) begin
                hold_cnt <= 3000;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RADIUS) radius_m = data[23:0];
    endtask

    task automatic drain();
        while (fix_queue.size() > 0 || s_tvalid || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pack_fix(longint lat, longint lon);
        logic [30:0] la;
        logic [31:0] lo;
        la = lat[30:0];
        lo = lon[31:0];
        return {1'b0, lo, la};
    endfunction

    function automatic longint rand_lat();
        return longint'($urandom_range(1800000000)) - 900000000;
    endfunction

    function automatic longint rand_lon();
        return longint'($signed($urandom()));
    endfunction

    // mostly short hops along a track, some long jumps and raw-range extremes
    task automatic queue_random(input int n);
        longint lat, lon;
        lat = rand_lat();
        lon = rand_lon();
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1: begin
                    lat = rand_lat();
                    lon = rand_lon();
                end
                2: begin
                    lat = longint'($signed(31'($urandom())));
                    lon = rand_lon();
                end
                default: begin
                    lat += longint'($urandom_range(20000)) - 10000;
                    lon += longint'($urandom_range(20000)) - 10000;
                    if (lat > 900000000) lat = 900000000;
                    if (lat < -900000000) lat = -900000000;
                    if (lon > 2147483647) lon -= 64'd4294967296;
                    if (lon < -2147483648) lon += 64'd4294967296;
                end
            endcase
            fix_queue.push_back(pack_fix(lat, lon));
        end
    endtask

    logic [31:0] radius_plan [6];

    initial begin
        radius_m  = 6371000;
        last_lat  = 0;
        last_lon  = 0;
        have_fix  = 1'b0;
        odo_total = 0;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        radius_plan = '{32'd6371000, 32'd1, 32'd16777215, 32'd0,
                        32'd6371000, 32'd6371000};
        radius_plan[4] = $urandom_range(16777215, 1);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, wraps, antipodes, raw latitude beyond a quarter turn
        tx_idle_pct = 20;
        rx_idle_pct = 63;
        fix_queue.push_back(pack_fix(0, 0));
        fix_queue.push_back(pack_fix(0, 0));
        fix_queue.push_back(pack_fix(0, 1800000000));
        fix_queue.push_back(pack_fix(900000000, 1800000000));
        fix_queue.push_back(pack_fix(-900000000, -1800000000));
        fix_queue.push_back(pack_fix(0, 1799999999));
        fix_queue.push_back(pack_fix(0, -1800000000));
        fix_queue.push_back(pack_fix(0, 2147483647));
        fix_queue.push_back(pack_fix(0, -2147483648));
        fix_queue.push_back(pack_fix(1073741823, 0));
        fix_queue.push_back(pack_fix(-1073741824, 0));
        fix_queue.push_back(pack_fix(1073741823, 1800000000));
        fix_queue.push_back(pack_fix(451234567, -123456789));
        fix_queue.push_back(pack_fix(451234568, -123456788));
        drain();

        for (int p = 0; p < 6; p++) begin
            reg_write(ADDR_RADIUS, radius_plan[p]);
            if (p == 2) reg_write(ADDR_UNUSED, $urandom());
            if (p == 2) begin
                tx_idle_pct = 63;
                rx_idle_pct = 20;
            end else if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long receiver stall while fixes keep coming
            if (p == 1) hold_at = cycle_count + 50;
            if (p == 2) begin
                fix_queue.push_back(pack_fix(-900000000, 0));
                fix_queue.push_back(pack_fix(900000000, 1800000000));
            end
            queue_random(RANDOM_PER_PHASE);
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
